// File: hw/rtl/stepper_ramp_step_generator_assert.svh
// Assertion macros for the stepper ramp step generator
`ifndef STEPPER_RAMP_STEP_GENERATOR_ASSERT_SVH
`define STEPPER_RAMP_STEP_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define SRSG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SRSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SRSG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SRSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/srsg_pkg.sv
// Shared types and constants of the stepper ramp step generator
package srsg_pkg;
   localparam int unsigned TICK_FREQ_CONST = 256000000;
   localparam int unsigned POS_WIDTH = 24;
   localparam int unsigned FREQ_W = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RAMP_W = 24;
   localparam int unsigned BRAKE_MARGIN = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_REQUEST = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ_MINIMUM = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_RATE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_HIGH = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAVEL_MAX = 3'd5;

   localparam logic [1:0] MODE_JOG = 2'd0;
   localparam logic [1:0] MODE_TARGET = 2'd1;
   localparam logic [1:0] MODE_HOME = 2'd2;

   localparam logic [1:0] HOME_SEEK = 2'd0;
   localparam logic [1:0] HOME_BRAKE = 2'd1;
   localparam logic [1:0] HOME_BACKOFF = 2'd2;
   localparam logic [1:0] HOME_IDLE = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic signed [23:0] target_pos;
      logic jog_enable;
      logic jog_dir;
      logic home_sensor;
   } req_type;

   typedef struct packed {
      logic step_level;
      logic dir_level;
      logic [31:0] next_interval;
      logic signed [23:0] position;
      logic homed;
      logic move_done;
   } rsp_type;
endpackage

// File: hw/rtl/srsg_stream_if.sv
// Valid/ready channel interface
interface srsg_stream_if #(parameter type PAYLOAD_TYPE = logic);
   logic valid;
   logic ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/stepper_ramp_step_generator.sv
// Stepper ramp step generator: trapezoidal ramp planner with bit-serial arithmetic
//  channel | dir | handshake       | payload
//  req     | in  | valid/ready     | mode, target_pos, jog_enable, jog_dir, home_sensor
//  rsp     | out | valid/ready     | step_level, dir_level, next_interval, position, ...
//  csr     | in  | write enable    | index, 32-bit data
// One transaction at a time. For a high-phase event or a step without retiming, the result
// goes from planning straight to the output stage; a period-only recompute adds a divide,
// and a frequency change adds a shift-add product, then a divide.
// Reset is synchronous; it loads the default registers and runs a divide
// for the initial period before the first transaction is accepted.
// A stalled result holds in the output register; the next transaction is taken and
// planned meanwhile and waits in the output stage until the register is free.
module stepper_ramp_step_generator #(
   parameter int unsigned TickFreq = srsg_pkg::TICK_FREQ_CONST
) (
   input logic clock,
   input logic reset,
   srsg_stream_if.sink req,
   srsg_stream_if.source rsp,
   input logic csr_write_enable,
   input logic [srsg_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [srsg_pkg::CSR_DATA_W-1:0] csr_write_data
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_PLAN = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_APPLY = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // frequency update applied after the product
   localparam logic [2:0] OP_NONE = 3'd0;
   localparam logic [2:0] OP_SPEED_UP = 3'd1;
   localparam logic [2:0] OP_BRAKE_MIN = 3'd2;
   localparam logic [2:0] OP_SLOW_FLOOR = 3'd3;
   localparam logic [2:0] OP_SLOW_TO_REQ = 3'd4;
   localparam logic [2:0] OP_SLOW_JUMP = 3'd5;

   localparam logic [31:0] TICK_K = 32'(TickFreq);

   state_type state_ff, state_in;
   logic [31:0] freq_req_ff, freq_min_ff;
   logic [15:0] accel_ff, pulse_hi_ff;
   logic signed [23:0] tmin_ff, tmax_ff;

   logic phase_ff, phase_in;
   logic [31:0] freq_ff, freq_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] low_ff, low_in;
   logic [23:0] ramp_ff, ramp_in;
   logic [23:0] pos_ff, pos_in;
   logic mdir_ff, mdir_in, dpin_ff, dpin_in;
   logic [1:0] hstage_ff, hstage_in;
   logic hdone_ff, hdone_in;

   srsg_pkg::req_type item_ff, item_in;
   // op: speed up, brake to min, slow with floor but no ramp count, jog slowdown to req,
   //     jog slowdown with jump to req
   logic [2:0] op_ff, op_in;
   logic retime_ff, retime_in;
   logic stepped_ff, stepped_in, stopped_ff, stopped_in, done_ff, done_in;
   logic advance_ff, advance_in;

   logic [47:0] prod_ff, prod_in;
   logic [31:0] mcand_ff, mcand_in;
   logic [15:0] mplier_ff, mplier_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvsr_ff, dvsr_in;

   srsg_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [25:0] pos_s, tgt_s, dist_s, reach_s;
   logic signed [25:0] tmin_s, tmax_s;
   logic [32:0] rem_sh;
   logic [48:0] fsum;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff; freq_in = freq_ff; period_in = period_ff; low_in = low_ff;
      ramp_in = ramp_ff; pos_in = pos_ff; mdir_in = mdir_ff; dpin_in = dpin_ff;
      hstage_in = hstage_ff; hdone_in = hdone_ff;
      item_in = item_ff; op_in = op_ff; retime_in = retime_ff;
      stepped_in = stepped_ff; stopped_in = stopped_ff; done_in = done_ff;
      advance_in = advance_ff;
      prod_in = prod_ff; mcand_in = mcand_ff; mplier_in = mplier_ff; cnt_in = cnt_ff;
      rem_in = rem_ff; quo_in = quo_ff; dvsr_in = dvsr_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      pos_s = 26'(signed'(pos_ff));
      tgt_s = 26'(item_ff.target_pos);
      tmin_s = 26'(tmin_ff);
      tmax_s = 26'(tmax_ff);
      reach_s = signed'({2'b00, ramp_ff}) + 26'sd10;
      dist_s = '0;
      rem_sh = {rem_ff[31:0], quo_ff[31]};
      fsum = {17'd0, freq_ff} + {1'b0, prod_ff};
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               item_in = req.payload;
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            op_in = OP_NONE; retime_in = 1'b0; stepped_in = 1'b0; stopped_in = 1'b0;
            done_in = 1'b0; advance_in = 1'b0;
            state_in = ST_OUT;
            if (phase_ff) begin
               phase_in = 1'b0;
            end else if (item_ff.mode == srsg_pkg::MODE_HOME && !hdone_ff) begin
               case (hstage_ff)
                  srsg_pkg::HOME_SEEK: begin
                     dpin_in = 1'b1;
                     if (item_ff.home_sensor) hstage_in = srsg_pkg::HOME_BRAKE;
                     else begin
                        stepped_in = 1'b1;
                        if (freq_ff < freq_req_ff) begin
                           op_in = OP_SPEED_UP; retime_in = 1'b1;
                        end
                     end
                  end
                  srsg_pkg::HOME_BRAKE: begin
                     if (freq_ff <= freq_min_ff) begin
                        dpin_in = 1'b0; hstage_in = srsg_pkg::HOME_BACKOFF;
                     end else begin
                        stepped_in = 1'b1; op_in = OP_SLOW_FLOOR; retime_in = 1'b1;
                     end
                  end
                  srsg_pkg::HOME_BACKOFF: begin
                     if (!item_ff.home_sensor) begin
                        dpin_in = 1'b0; hstage_in = srsg_pkg::HOME_IDLE;
                        pos_in = tmax_ff; mdir_in = 1'b0; hdone_in = 1'b1; done_in = 1'b1;
                     end else stepped_in = 1'b1;
                  end
                  default: ;
               endcase
            end else if (item_ff.mode == srsg_pkg::MODE_TARGET) begin
               if (tgt_s < tmin_s) tgt_s = tmin_s;
               if (tgt_s > tmax_s) tgt_s = tmax_s;
               if (tgt_s == pos_s) done_in = 1'b1;
               else begin
                  stepped_in = 1'b1; advance_in = 1'b1;
                  if ((tgt_s < pos_s && mdir_ff) || (tgt_s > pos_s && !mdir_ff)) begin
                     if (freq_ff > freq_min_ff) begin
                        op_in = OP_BRAKE_MIN; retime_in = 1'b1;
                     end else begin mdir_in = !mdir_ff; dpin_in = !mdir_ff; end
                  end else begin
                     dist_s = (pos_s > tgt_s) ? pos_s - tgt_s : tgt_s - pos_s;
                     if (dist_s <= reach_s) begin
                        op_in = OP_BRAKE_MIN; retime_in = 1'b1;
                     end else if (freq_ff < freq_req_ff) begin
                        op_in = OP_SPEED_UP; retime_in = 1'b1;
                     end
                  end
               end
            end else begin
               if ((!item_ff.jog_enable && freq_ff <= freq_min_ff) ||
                   (pos_s <= tmin_s && !item_ff.jog_dir) ||
                   (pos_s >= tmax_s && item_ff.jog_dir)) begin
                  stopped_in = 1'b1; retime_in = 1'b1;
               end else begin
                  stepped_in = 1'b1; advance_in = 1'b1;
                  if (!item_ff.jog_enable) begin op_in = OP_BRAKE_MIN; retime_in = 1'b1; end
                  else if (mdir_ff != item_ff.jog_dir) begin
                     if (freq_ff > freq_min_ff) begin
                        op_in = OP_BRAKE_MIN; retime_in = 1'b1;
                     end else begin mdir_in = item_ff.jog_dir; dpin_in = item_ff.jog_dir; end
                  end else if ((pos_s - reach_s < tmin_s && !item_ff.jog_dir) ||
                               (pos_s + reach_s > tmax_s && item_ff.jog_dir)) begin
                     op_in = OP_BRAKE_MIN; retime_in = 1'b1;
                  end else if (freq_req_ff < freq_min_ff) begin
                     if (freq_ff > freq_min_ff) begin
                        op_in = OP_SLOW_JUMP; retime_in = 1'b1;
                     end
                  end else if (freq_ff < freq_req_ff) begin
                     op_in = OP_SPEED_UP; retime_in = 1'b1;
                  end else if (freq_ff > freq_req_ff) begin
                     op_in = OP_SLOW_TO_REQ; retime_in = 1'b1;
                  end
               end
            end
            if (op_in != OP_NONE) begin
               prod_in = '0; mcand_in = period_ff; mplier_in = accel_ff; cnt_in = 6'd16;
               state_in = ST_MUL;
            end else if (retime_in) begin
               dvsr_in = stopped_in ? freq_min_ff : freq_ff;
               rem_in = '0; quo_in = TICK_K; cnt_in = 6'd32; state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            // shift-add, one multiplier bit per cycle, msb first
            prod_in = {prod_ff[46:0], 1'b0} + (mplier_ff[15] ? {16'd0, mcand_ff} : 48'd0);
            mplier_in = {mplier_ff[14:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            case (op_ff)
               OP_SPEED_UP: begin
                  freq_in = (fsum > {17'd0, freq_req_ff}) ? freq_req_ff : fsum[31:0];
                  if (item_ff.mode == srsg_pkg::MODE_TARGET || (item_ff.mode != srsg_pkg::MODE_HOME)
                      || hdone_ff) begin
                     if (ramp_ff != 24'hFFFFFF) ramp_in = ramp_ff + 24'd1;
                  end
               end
               default: begin
                  freq_in = ({16'd0, freq_ff} <= prod_ff) ? 32'd0 : freq_ff - prod_ff[31:0];
                  if (op_ff inside {OP_BRAKE_MIN, OP_SLOW_FLOOR}) begin
                     if (freq_in < freq_min_ff) freq_in = freq_min_ff;
                  end else if (op_ff == OP_SLOW_JUMP) begin
                     if (freq_in <= freq_min_ff) freq_in = freq_req_ff;
                  end else begin
                     if (freq_in < freq_req_ff) freq_in = freq_req_ff;
                  end
                  if (op_ff != OP_SLOW_FLOOR && ramp_ff != 24'd0) ramp_in = ramp_ff - 24'd1;
               end
            endcase
            dvsr_in = freq_in;
            rem_in = '0; quo_in = TICK_K; cnt_in = 6'd32; state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_sh >= {1'b0, dvsr_ff}) begin
               rem_in = rem_sh - {1'b0, dvsr_ff}; quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh; quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               period_in = (dvsr_ff == 32'd0) ? 32'hFFFFFFFF : quo_in;
               if (!stopped_ff)
                  low_in = (period_in > {16'd0, pulse_hi_ff}) ?
                           period_in - {16'd0, pulse_hi_ff} : 32'd0;
               // the divide after reset only sets up the period; it gives no result
               state_in = retime_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               if (advance_ff) pos_in = mdir_ff ? pos_ff + 24'd1 : pos_ff - 24'd1;
               if (stepped_ff) phase_in = 1'b1;
               rsp_in.step_level = stepped_ff;
               rsp_in.dir_level = dpin_ff;
               rsp_in.next_interval = stepped_ff ? {16'd0, pulse_hi_ff} :
                                      (stopped_ff ? period_ff : low_ff);
               rsp_in.position = signed'(pos_in);
               rsp_in.homed = hdone_ff;
               rsp_in.move_done = done_ff;
               rsp_valid_in = 1'b1;
               stepped_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DIV;
         freq_req_ff <= 32'd25600; freq_min_ff <= 32'd2560;
         accel_ff <= 16'd16; pulse_hi_ff <= 16'd10;
         tmin_ff <= 24'sd0; tmax_ff <= 24'sd100000;
         phase_ff <= 1'b0; freq_ff <= 32'd2560; ramp_ff <= '0; pos_ff <= '0;
         mdir_ff <= 1'b1; dpin_ff <= 1'b1; hstage_ff <= srsg_pkg::HOME_SEEK;
         hdone_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         stopped_ff <= 1'b0; stepped_ff <= 1'b0; advance_ff <= 1'b0; done_ff <= 1'b0;
         dvsr_ff <= 32'd2560; rem_ff <= '0; quo_ff <= TICK_K; cnt_ff <= 6'd32;
         op_ff <= OP_NONE; retime_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in; freq_ff <= freq_in; ramp_ff <= ramp_in; pos_ff <= pos_in;
         mdir_ff <= mdir_in; dpin_ff <= dpin_in; hstage_ff <= hstage_in; hdone_ff <= hdone_in;
         rsp_valid_ff <= rsp_valid_in;
         stopped_ff <= stopped_in; stepped_ff <= stepped_in; advance_ff <= advance_in;
         done_ff <= done_in; dvsr_ff <= dvsr_in; rem_ff <= rem_in; quo_ff <= quo_in;
         cnt_ff <= cnt_in; op_ff <= op_in; retime_ff <= retime_in;
         if (csr_write_enable) begin
            case (csr_index)
               srsg_pkg::CSR_FREQ_REQUEST: freq_req_ff <= csr_write_data;
               srsg_pkg::CSR_FREQ_MINIMUM: freq_min_ff <= csr_write_data;
               srsg_pkg::CSR_ACCEL_RATE: accel_ff <= csr_write_data[15:0];
               srsg_pkg::CSR_PULSE_HIGH: pulse_hi_ff <= csr_write_data[15:0];
               srsg_pkg::CSR_TRAVEL_MIN: tmin_ff <= signed'(csr_write_data[23:0]);
               srsg_pkg::CSR_TRAVEL_MAX: tmax_ff <= signed'(csr_write_data[23:0]);
               default: ;
            endcase
         end
      end
      period_ff <= reset ? 32'd100000 : period_in;
      low_ff <= reset ? 32'd99990 : low_in;
      item_ff <= item_in; prod_ff <= prod_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      rsp_ff <= rsp_in;
   end

`include "stepper_ramp_step_generator_assert.svh"
   `SRSG_ASSERT_IMPL(a_ready_only_idle, clock, reset, req.ready, state_ff == ST_IDLE)
   `SRSG_ASSERT_NEXT(a_accept_plans, clock, reset, req.valid && req.ready, state_ff == ST_PLAN)
   `SRSG_ASSERT_NEXT(a_out_gives_rsp, clock, reset, state_ff == ST_OUT, rsp_valid_ff)
endmodule
